// ===== rtl/rsk_pkg.sv =====
// ----------------------------------------------------------------------------
// rsk_pkg
// Shared types and codes for the record sorter.
// ----------------------------------------------------------------------------
package rsk_pkg;

  localparam int KeyW  = 64;
  localparam int RecW  = 128;
  localparam int StatW = 3;

  localparam logic [StatW-1:0] ST_LOADED = 3'd0;
  localparam logic [StatW-1:0] ST_OUT    = 3'd1;
  localparam logic [StatW-1:0] ST_FULL   = 3'd2;
  localparam logic [StatW-1:0] ST_EMPTY  = 3'd3;
  localparam logic [StatW-1:0] ST_BUSY   = 3'd4;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Status of the merge engine as seen by the controller.
  typedef struct packed {
    logic busy;
    logic sel;
  } srt_stat_t;

endpackage

// ===== rtl/rsk_merge.sv =====
// ----------------------------------------------------------------------------
// rsk_merge
// Two record banks and a bottom-up merge sequencer that merges runs back and forth between them.
// ----------------------------------------------------------------------------
module rsk_merge import rsk_pkg::*; #(
  parameter int MAX_RECORDS = 1024,
  parameter int AW = $clog2(MAX_RECORDS),
  parameter int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [CW-1:0]   count,
  input  logic            load_we,
  input  logic [AW-1:0]   load_addr,
  input  logic [RecW-1:0] load_data,
  input  logic [AW-1:0]   ext_raddr,
  output logic [RecW-1:0] rd_data,
  output srt_stat_t       stat
);

  localparam int IW = CW + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PASS  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_RDA   = 3'd3;
  localparam logic [2:0] S_RDB   = 3'd4;
  localparam logic [2:0] S_CAPB  = 3'd5;
  localparam logic [2:0] S_MERGE = 3'd6;
  localparam logic [2:0] S_FILL  = 3'd7;

  logic [RecW-1:0] mem0 [MAX_RECORDS];
  logic [RecW-1:0] mem1 [MAX_RECORDS];
  logic [RecW-1:0] rdata0, rdata1;

  logic [2:0]      state;
  logic            sel;
  logic [IW-1:0]   n, run_w, lo, mid, hi, a, b, k;
  logic [RecW-1:0] ha, hb;
  logic            fill_b;

  logic [IW-1:0]   mid_c, hi_c;
  logic            take_b;
  logic [AW-1:0]   raddr;
  logic            mwe;
  logic [RecW-1:0] mdata;

  assign mid_c  = (lo + run_w > n) ? n : lo + run_w;
  assign hi_c   = (lo + (run_w << 1) > n) ? n : lo + (run_w << 1);
  assign take_b = (b < hi) && ((a >= mid) || (hb[KeyW-1:0] < ha[KeyW-1:0]));
  assign mwe    = (state == S_MERGE) && (k != hi);
  assign mdata  = take_b ? hb : ha;

  always_comb begin
    case (state)
      S_RDA:   raddr = a[AW-1:0];
      S_RDB:   raddr = b[AW-1:0];
      S_MERGE: raddr = take_b ? b[AW-1:0] + AW'(1) : a[AW-1:0] + AW'(1);
      S_IDLE:  raddr = ext_raddr;
      default: raddr = a[AW-1:0];
    endcase
  end

  // Bank 0 takes loads; merges write the bank not being read.
  always_ff @(posedge clk) begin
    if ((load_we && state == S_IDLE) || (mwe && sel)) begin
      mem0[mwe ? k[AW-1:0] : load_addr] <= mwe ? mdata : load_data;
    end
    if (mwe && !sel) begin
      mem1[k[AW-1:0]] <= mdata;
    end
    rdata0 <= mem0[raddr];
    rdata1 <= mem1[raddr];
  end

  assign rd_data   = sel ? rdata1 : rdata0;
  assign stat.busy = (state != S_IDLE);
  assign stat.sel  = sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            n     <= IW'(count);
            run_w <= IW'(1);
            sel   <= 1'b0;
            state <= S_PASS;
          end
        end
        S_PASS: begin
          if (run_w < n) begin
            lo    <= '0;
            state <= S_RUN;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RUN: begin
          if (lo >= n) begin
            sel   <= ~sel;
            run_w <= run_w << 1;
            state <= S_PASS;
          end else begin
            mid   <= mid_c;
            hi    <= hi_c;
            a     <= lo;
            b     <= mid_c;
            k     <= lo;
            state <= S_RDA;
          end
        end
        S_RDA:  state <= S_RDB;
        S_RDB: begin
          ha    <= rd_data;
          state <= S_CAPB;
        end
        S_CAPB: begin
          hb    <= rd_data;
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (k == hi) begin
            lo    <= hi;
            state <= S_RUN;
          end else begin
            k      <= k + IW'(1);
            fill_b <= take_b;
            if (take_b) b <= b + IW'(1);
            else        a <= a + IW'(1);
            state  <= S_FILL;
          end
        end
        S_FILL: begin
          if (fill_b) hb <= rd_data;
          else        ha <= rd_data;
          state <= S_MERGE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/record_sort_by_key.sv =====
// ----------------------------------------------------------------------------
// record_sort_by_key
// Load-then-drain stable record sorter keyed on a 64-bit unsigned key.
// ----------------------------------------------------------------------------
// A load, a refused request or an empty read answers in the cycle after its beat
// is taken; a read from a sorted set answers after the read and data states.
// The first read after loading also runs a merge sort on one shared compare unit
// before it answers. One beat is in work at a time; the input is ready again
// once the result beat is taken. rst clears the control state, count, read
// position, drain flag and m_tvalid; stored records are not cleared.
module record_sort_by_key import rsk_pkg::*; #(
  parameter int MAX_RECORDS = 1024
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,  // sort_key[63:0], companion_word[127:64]
  input  logic [0:0]   s_tuser,  // func[0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // out_key[63:0], out_companion[127:64]
  output logic [2:0]   m_tuser,  // status[2:0]
  output logic         m_tlast   // last_out
);

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  localparam logic [1:0] T_IDLE = 2'd0;
  localparam logic [1:0] T_SORT = 2'd1;
  localparam logic [1:0] T_READ = 2'd2;
  localparam logic [1:0] T_DATA = 2'd3;

  logic [1:0]      tstate;
  logic [CW-1:0]   count, pos;
  logic            draining;
  logic            acc, start, load_we;
  logic [RecW-1:0] rd_data;
  srt_stat_t       stat;

  assign s_tready = (tstate == T_IDLE) && !m_tvalid;
  assign acc      = s_tvalid && s_tready;
  assign load_we  = acc && (s_tuser[0] == FUNC_LOAD) && !draining
                    && (count < CW'(MAX_RECORDS));
  assign start    = acc && (s_tuser[0] == FUNC_READ) && (count != '0) && !draining;

  rsk_merge #(.MAX_RECORDS(MAX_RECORDS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .count     (count),
    .load_we   (load_we),
    .load_addr (count[AW-1:0]),
    .load_data (s_tdata),
    .ext_raddr (pos[AW-1:0]),
    .rd_data   (rd_data),
    .stat      (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate   <= T_IDLE;
      count    <= '0;
      pos      <= '0;
      draining <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (tstate)
        T_IDLE: begin
          if (acc) begin
            if (s_tuser[0] == FUNC_LOAD) begin
              m_tvalid <= 1'b1;
              m_tdata  <= '0;
              m_tlast  <= 1'b0;
              if (draining) begin
                m_tuser <= ST_BUSY;
              end else if (!load_we) begin
                m_tuser <= ST_FULL;
              end else begin
                m_tuser <= ST_LOADED;
                count   <= count + CW'(1);
              end
            end else if (count == '0) begin
              m_tvalid <= 1'b1;
              m_tdata  <= '0;
              m_tlast  <= 1'b0;
              m_tuser  <= ST_EMPTY;
            end else if (start) begin
              tstate <= T_SORT;
            end else begin
              tstate <= T_READ;
            end
          end
        end
        T_SORT: begin
          if (!stat.busy) begin
            draining <= 1'b1;
            pos      <= '0;
            tstate   <= T_READ;
          end
        end
        T_READ: tstate <= T_DATA;
        T_DATA: begin
          m_tvalid <= 1'b1;
          m_tdata  <= rd_data;
          m_tuser  <= ST_OUT;
          if (pos + CW'(1) == count) begin
            m_tlast  <= 1'b1;
            count    <= '0;
            pos      <= '0;
            draining <= 1'b0;
          end else begin
            m_tlast <= 1'b0;
            pos     <= pos + CW'(1);
          end
          tstate <= T_IDLE;
        end
        default: tstate <= T_IDLE;
      endcase
    end
  end

endmodule
